/* rtl/drfd_pkg.sv */
`timescale 1ns / 1ps

package drfd_pkg;

	// Default buffer size in pixels.
	localparam int PIXEL_COUNT_DEF = 32768;

	// Entries in the queue between parser and span formatter (a power of two).
	localparam int QUEUE_DEPTH = 2;

	// Byte codes of the file format.
	localparam logic [7:0] MARK_FRAME = 8'h53;
	localparam logic [7:0] CMD_RUN    = 8'h56;
	localparam logic [7:0] CMD_SKIP   = 8'h54;
	localparam logic [7:0] CMD_LIT    = 8'h57;

	// Kinds of result events.
	typedef enum logic [1:0] {
		EV_SPAN   = 2'd0,
		EV_FRAME  = 2'd1,
		EV_ERROR  = 2'd2,
		EV_HEADER = 2'd3
	} event_kind_t;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HDR    = 4'd1,
		PH_WAIT   = 4'd2,
		PH_CMD    = 4'd3,
		PH_RUN_N  = 4'd4,
		PH_RUN_V  = 4'd5,
		PH_SKIP_N = 4'd6,
		PH_LIT_N  = 4'd7,
		PH_LIT_D  = 4'd8,
		PH_ERR    = 4'd9
	} phase_t;

	// Fixed-width part of one queued command.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  value;
		logic [7:0]  version;
	} cmd_t;

endpackage

/* rtl/drfd_byte_if.sv */
`timescale 1ns / 1ps

// Byte stream channel into the decoder.
interface drfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

/* rtl/drfd_event_if.sv */
`timescale 1ns / 1ps

// Event stream channel out of the decoder.
interface drfd_event_if;
	logic                  valid;
	logic                  ready;
	drfd_pkg::event_kind_t event_kind;
	logic [14:0]           start_index;
	logic [15:0]           span_length;
	logic [7:0]            pixel_value;
	logic [7:0]            format_version;
	logic                  clipped;

	modport source (
		output valid, output event_kind, output start_index, output span_length,
		output pixel_value, output format_version, output clipped, input ready
	);
	modport sink (
		input valid, input event_kind, input start_index, input span_length,
		input pixel_value, input format_version, input clipped, output ready
	);
endinterface

/* rtl/drfd_front.sv */
`timescale 1ns / 1ps

// Byte parser: tracks header and frame commands, keeps the pixel position
// and pushes one command per byte that produces an event.
module drfd_front #(
	parameter int PIXEL_COUNT = drfd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	drfd_byte_if.sink                            byte_in,
	input  logic                                 queue_full,
	output logic                                 push,
	output drfd_pkg::cmd_t                       cmd,
	output logic [$clog2(PIXEL_COUNT + 1) - 1:0] cmd_start,
	output logic [$clog2(PIXEL_COUNT + 1) - 1:0] cmd_count
);

	localparam int POS_W = $clog2(PIXEL_COUNT + 1);
	localparam logic [POS_W-1:0] PC_V = POS_W'(PIXEL_COUNT);
	localparam logic [POS_W-1:0] ONE_V = POS_W'(1);

	drfd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       hdr_q, hdr_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       pend_q, pend_d;
	logic [7:0]       ver_q, ver_d;

	logic             accept;
	logic [7:0]       b;
	logic             adv_en;
	logic [7:0]       adv_amt;
	logic [POS_W:0]   adv_sum;
	logic [POS_W-1:0] adv_pos;

	assign byte_in.ready = !queue_full;
	assign accept = byte_in.valid && !queue_full;
	assign b = byte_in.data_byte;

	// Parse state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= drfd_pkg::PH_IDLE;
			hdr_q   <= '0;
			pos_q   <= '0;
			pend_q  <= '0;
			ver_q   <= '0;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			pos_q   <= pos_d;
			pend_q  <= pend_d;
			ver_q   <= ver_d;
		end
	end

	// Next parse state and the command for the queue.
	always_comb begin
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		pos_d     = pos_q;
		pend_d    = pend_q;
		ver_d     = ver_q;
		push      = 1'b0;
		cmd.kind  = drfd_pkg::EV_SPAN;
		cmd.value = b;
		cmd_start = pos_q;
		cmd_count = ONE_V;
		adv_en    = 1'b0;
		adv_amt   = 8'd1;
		if (accept) begin
			if (byte_in.file_start) begin
				phase_d = drfd_pkg::PH_HDR;
				hdr_d   = 2'd1;
				pos_d   = '0;
				pend_d  = '0;
				ver_d   = '0;
			end else begin
				unique case (phase_q)
					drfd_pkg::PH_HDR: begin
						if (hdr_q < 2'd2) begin
							hdr_d = 2'd2;
						end else if (hdr_q == 2'd2) begin
							// Background value: fill the whole buffer.
							hdr_d     = 2'd3;
							push      = 1'b1;
							cmd_start = '0;
							cmd_count = PC_V;
						end else begin
							pos_d    = '0;
							push     = 1'b1;
							cmd.kind = drfd_pkg::EV_HEADER;
							if (b == drfd_pkg::MARK_FRAME) begin
								ver_d   = '0;
								phase_d = drfd_pkg::PH_CMD;
							end else begin
								ver_d   = b;
								phase_d = drfd_pkg::PH_WAIT;
							end
						end
					end
					drfd_pkg::PH_WAIT: begin
						if (b == drfd_pkg::MARK_FRAME) begin
							pos_d   = '0;
							phase_d = drfd_pkg::PH_CMD;
						end else begin
							phase_d  = drfd_pkg::PH_ERR;
							push     = 1'b1;
							cmd.kind = drfd_pkg::EV_ERROR;
						end
					end
					drfd_pkg::PH_CMD: begin
						if (b == drfd_pkg::MARK_FRAME) begin
							pos_d    = '0;
							push     = 1'b1;
							cmd.kind = drfd_pkg::EV_FRAME;
						end else if (b == drfd_pkg::CMD_RUN) begin
							phase_d = drfd_pkg::PH_RUN_N;
						end else if (b == drfd_pkg::CMD_SKIP) begin
							phase_d = drfd_pkg::PH_SKIP_N;
						end else if (b == drfd_pkg::CMD_LIT && ver_q != 8'd0) begin
							phase_d = drfd_pkg::PH_LIT_N;
						end else begin
							push   = 1'b1;
							adv_en = 1'b1;
						end
					end
					drfd_pkg::PH_RUN_N: begin
						pend_d  = b;
						phase_d = drfd_pkg::PH_RUN_V;
					end
					drfd_pkg::PH_RUN_V: begin
						phase_d = drfd_pkg::PH_CMD;
						if (pend_q != 8'd0) begin
							push      = 1'b1;
							cmd_count = {{(POS_W - 8){1'b0}}, pend_q};
							adv_en    = 1'b1;
							adv_amt   = pend_q;
							pend_d    = '0;
						end
					end
					drfd_pkg::PH_SKIP_N: begin
						adv_en  = 1'b1;
						adv_amt = b;
						phase_d = drfd_pkg::PH_CMD;
					end
					drfd_pkg::PH_LIT_N: begin
						pend_d  = b;
						phase_d = (b == 8'd0) ? drfd_pkg::PH_CMD : drfd_pkg::PH_LIT_D;
					end
					drfd_pkg::PH_LIT_D: begin
						push   = 1'b1;
						adv_en = 1'b1;
						pend_d = pend_q - 8'd1;
						if (pend_q == 8'd1) begin
							phase_d = drfd_pkg::PH_CMD;
						end
					end
					default: begin
						// Idle before a file and after an error: bytes are dropped.
					end
				endcase
			end
		end
		// Position advance saturates at the buffer end.
		adv_sum = {1'b0, pos_q} + {{(POS_W - 7){1'b0}}, adv_amt};
		adv_pos = (adv_sum > {1'b0, PC_V}) ? PC_V : adv_sum[POS_W-1:0];
		if (adv_en) begin
			pos_d = adv_pos;
		end
		cmd.version = ver_d;
	end

endmodule

/* rtl/drfd_queue.sv */
`timescale 1ns / 1ps

// Small command queue between the parser and the span formatter.
module drfd_queue #(
	parameter int PIXEL_COUNT = drfd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  drfd_pkg::cmd_t                       push_cmd,
	input  logic [$clog2(PIXEL_COUNT + 1) - 1:0] push_start,
	input  logic [$clog2(PIXEL_COUNT + 1) - 1:0] push_count,
	output logic                                 full,
	output logic                                 head_valid,
	input  logic                                 pop,
	output drfd_pkg::cmd_t                       head_cmd,
	output logic [$clog2(PIXEL_COUNT + 1) - 1:0] head_start,
	output logic [$clog2(PIXEL_COUNT + 1) - 1:0] head_count
);

	localparam int POS_W = $clog2(PIXEL_COUNT + 1);
	localparam int PTR_W = $clog2(drfd_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_V = (PTR_W + 1)'(drfd_pkg::QUEUE_DEPTH);

	drfd_pkg::cmd_t   cmd_q   [drfd_pkg::QUEUE_DEPTH];
	logic [POS_W-1:0] start_q [drfd_pkg::QUEUE_DEPTH];
	logic [POS_W-1:0] count_q [drfd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full       = (cnt_q == DEPTH_V);
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = cmd_q[rd_ptr_q];
	assign head_start = start_q[rd_ptr_q];
	assign head_count = count_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]   <= push_cmd;
			start_q[wr_ptr_q] <= push_start;
			count_q[wr_ptr_q] <= push_count;
		end
	end

	// Pointers and fill count; the depth is a power of two, so pointers wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/drfd_back.sv */
`timescale 1ns / 1ps

// Span formatter: clips spans at the buffer end and holds the output beat.
module drfd_back #(
	parameter int PIXEL_COUNT = drfd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  drfd_pkg::cmd_t                       head_cmd,
	input  logic [$clog2(PIXEL_COUNT + 1) - 1:0] head_start,
	input  logic [$clog2(PIXEL_COUNT + 1) - 1:0] head_count,
	output logic                                 pop,
	drfd_event_if.source                         event_out
);

	localparam int POS_W = $clog2(PIXEL_COUNT + 1);
	localparam logic [POS_W-1:0] PC_V = POS_W'(PIXEL_COUNT);

	logic                  valid_q;
	drfd_pkg::event_kind_t kind_q;
	logic [14:0]           start_q;
	logic [15:0]           len_q;
	logic [7:0]            value_q;
	logic [7:0]            version_q;
	logic                  clip_q;

	logic [POS_W-1:0]      avail;
	logic [POS_W-1:0]      len;
	logic [POS_W+14:0]     start_ext;
	logic [POS_W+15:0]     len_ext;
	logic [14:0]           start_n;
	logic [15:0]           len_n;
	logic                  clip_n;

	assign pop = head_valid && (!valid_q || event_out.ready);

	// Clipping of a span against the buffer end.
	always_comb begin
		avail     = PC_V - head_start;
		len       = (head_count < avail) ? head_count : avail;
		start_ext = {15'd0, head_start};
		len_ext   = {16'd0, len};
		start_n   = '0;
		len_n     = '0;
		clip_n    = 1'b0;
		if (head_cmd.kind == drfd_pkg::EV_SPAN) begin
			if (head_start >= PC_V) begin
				clip_n = 1'b1;
			end else begin
				start_n = start_ext[14:0];
				len_n   = len_ext[15:0];
				clip_n  = (head_count > avail);
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (event_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= head_cmd.kind;
			start_q   <= start_n;
			len_q     <= len_n;
			value_q   <= (head_cmd.kind == drfd_pkg::EV_SPAN) ? head_cmd.value : 8'd0;
			version_q <= head_cmd.version;
			clip_q    <= clip_n;
		end
	end

	assign event_out.valid          = valid_q;
	assign event_out.event_kind     = kind_q;
	assign event_out.start_index    = start_q;
	assign event_out.span_length    = len_q;
	assign event_out.pixel_value    = value_q;
	assign event_out.format_version = version_q;
	assign event_out.clipped        = clip_q;

endmodule

/* rtl/delta_rle_frame_decoder.sv */
`timescale 1ns / 1ps
// An accepted byte that yields an event is written into the command queue, then registered in the output beat.
// Throughput: one byte per cycle; the parser runs ahead of a stalled output
// until the two-entry command queue fills, then holds ready low.
// Reset (arst_n, asynchronous, active low) puts the parser in idle awaiting
// a file start and empties the queue and the output beat.

module delta_rle_frame_decoder #(
	parameter int PIXEL_COUNT = drfd_pkg::PIXEL_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	drfd_byte_if.sink    byte_in,
	drfd_event_if.source event_out
);

	localparam int POS_W = $clog2(PIXEL_COUNT + 1);

	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	drfd_pkg::cmd_t   push_cmd;
	drfd_pkg::cmd_t   head_cmd;
	logic [POS_W-1:0] push_start;
	logic [POS_W-1:0] push_count;
	logic [POS_W-1:0] head_start;
	logic [POS_W-1:0] head_count;

	drfd_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.queue_full (full),
		.push       (push),
		.cmd        (push_cmd),
		.cmd_start  (push_start),
		.cmd_count  (push_count)
	);

	drfd_queue #(.PIXEL_COUNT(PIXEL_COUNT)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_start (push_start),
		.push_count (push_count),
		.full       (full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd),
		.head_start (head_start),
		.head_count (head_count)
	);

	drfd_back #(.PIXEL_COUNT(PIXEL_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.head_start (head_start),
		.head_count (head_count),
		.pop        (pop),
		.event_out  (event_out)
	);

endmodule
